[rtl/gap_checked_reservation_table_assert.svh]
// assertion macros shared by the checker
`ifndef GAP_CHECKED_RESERVATION_TABLE_ASSERT_SVH
`define GAP_CHECKED_RESERVATION_TABLE_ASSERT_SVH

// consequent checked in the same cycle
`define GRT_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("grt: same-cycle check failed");

// consequent checked in the next cycle
`define GRT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("grt: next-cycle check failed");

`endif

[rtl/grt_pkg.sv]
package grt_pkg;

  localparam int GAP_BITS      = 16;
  localparam int REQ_TIME_BITS = 16;
  localparam int COUNT_BITS    = 7;
  localparam int STATUS_BITS   = 2;
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_ADDR_BITS = 3;
  localparam int LANES         = 8;
  localparam int LANE_CNT_BITS = 4;

  localparam logic [GAP_BITS-1:0] MIN_GAP_RESET = 16'd3;

  typedef enum logic [STATUS_BITS-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_CONFLICT = 2'd1,
    STATUS_FULL     = 2'd2
  } status_t;

  typedef enum logic {
    REQ_RESERVE = 1'b0,
    REQ_COUNT   = 1'b1
  } req_type_t;

  // register index as seen in the word address
  typedef enum logic {
    REG_MIN_GAP = 1'b0,
    REG_NONE    = 1'b1
  } reg_index_t;

  typedef logic [COUNT_BITS-1:0] count_t;

  typedef struct packed {
    logic le;
    logic near;
  } cell_flags_t;

  function automatic logic [LANE_CNT_BITS-1:0] popcount_lanes(input logic [LANES-1:0] v);
    logic [LANE_CNT_BITS-1:0] acc;
    acc = '0;
    for (int k = 0; k < LANES; k++) begin
      acc = acc + LANE_CNT_BITS'(v[k]);
    end
    return acc;
  endfunction

endpackage

[rtl/grt_cell.sv]
module grt_cell #(
  parameter int TIME_BITS = 16
) (
  input  logic                          clk,
  input  logic                          shift_en,
  input  logic [TIME_BITS-1:0]          time_in,
  output logic [TIME_BITS-1:0]          time_out,
  input  logic [TIME_BITS-1:0]          req_time,
  input  logic [grt_pkg::GAP_BITS-1:0]  min_gap,
  input  logic                          occupied,
  output grt_pkg::cell_flags_t          flags
);
  import grt_pkg::*;

  localparam int DW = (TIME_BITS > GAP_BITS) ? TIME_BITS : GAP_BITS;

  logic [TIME_BITS-1:0] time_r;
  logic [TIME_BITS-1:0] delta;

  // insertion moves every stored time one cell along the chain
  always_ff @(posedge clk) begin
    if (shift_en) begin
      time_r <= time_in;
    end
  end

  assign time_out = time_r;

  always_comb begin
    delta      = (time_r >= req_time) ? (time_r - req_time) : (req_time - time_r);
    flags.le   = occupied && (time_r <= req_time);
    flags.near = occupied && (DW'(delta) <= DW'(min_gap));
  end

endmodule

[rtl/grt_scan.sv]
module grt_scan #(
  parameter int PAD = 64
) (
  input  logic             clk,
  input  logic             load,
  input  logic             step,
  input  logic [PAD-1:0]   le_in,
  input  logic [PAD-1:0]   near_in,
  output grt_pkg::count_t  count_nxt,
  output logic             conflict_nxt
);
  import grt_pkg::*;

  logic [PAD-1:0] le_r;
  logic [PAD-1:0] near_r;
  count_t         count_r;
  logic           conflict_r;

  // running totals including the chunk at the bottom of the flag line
  assign count_nxt    = count_r + COUNT_BITS'(popcount_lanes(le_r[LANES-1:0]));
  assign conflict_nxt = conflict_r | (|near_r[LANES-1:0]);

  always_ff @(posedge clk) begin
    if (load) begin
      le_r       <= le_in;
      near_r     <= near_in;
      count_r    <= '0;
      conflict_r <= 1'b0;
    end else if (step) begin
      le_r       <= le_r >> LANES;
      near_r     <= near_r >> LANES;
      count_r    <= count_nxt;
      conflict_r <= conflict_nxt;
    end
  end

endmodule

[rtl/gap_checked_reservation_table.sv]
// Reservation table: a set of up to CAPACITY time values with a minimum gap.
// Input channel: a request (in_req_type, in_request_time) is taken at a rising
// edge with start high and busy low. A reserve request stores the time unless
// a stored time lies within min_gap of it (status conflict) or the table is
// full (status full). A count request returns how many stored times are at or
// below the given time, modulo 128.
// Result channel: out_valid is high for exactly one cycle per request with
// out_status and out_count_at_or_below; the receiver always takes it.
// Sequence: at the accepting edge the request is registered; in S_CMP every
// cell compares it by broadcast; in S_SCAN the flag line that sums the
// compare results of the cell chain is walked eight cells per cycle, in
// NCHUNK = ceil(CAPACITY / 8) chunks. The result shows as busy drops, in the
// same cycle, so one request is served at a time. Configuration: min_gap over
// the APB port at address 0; the user writes it only while busy is low; the
// block does not enforce this. Reset empties the table and sets min_gap to 3.
module gap_checked_reservation_table #(
  parameter int CAPACITY  = 64,
  parameter int TIME_BITS = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 start,
  output logic                                 busy,
  input  logic                                 in_req_type,
  input  logic [grt_pkg::REQ_TIME_BITS-1:0]    in_request_time,
  output logic                                 out_valid,
  output logic [grt_pkg::STATUS_BITS-1:0]      out_status,
  output logic [grt_pkg::COUNT_BITS-1:0]       out_count_at_or_below,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [grt_pkg::CFG_ADDR_BITS-1:0]    paddr,
  input  logic [grt_pkg::CFG_DATA_BITS-1:0]    pwdata,
  output logic [grt_pkg::CFG_DATA_BITS-1:0]    prdata,
  output logic                                 pready
);
  import grt_pkg::*;

  localparam int NCHUNK = (CAPACITY + LANES - 1) / LANES;
  localparam int PAD    = NCHUNK * LANES;
  localparam int CHW    = (NCHUNK > 1) ? $clog2(NCHUNK) : 1;
  localparam int FILLW  = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_SCAN
  } state_t;

  state_t                 state_r;
  logic [CHW-1:0]         chunk_r;
  logic [FILLW-1:0]       fill_r;
  logic [GAP_BITS-1:0]    min_gap_r;
  req_type_t              kind_r;
  logic [TIME_BITS-1:0]   req_time_r;
  logic                   out_valid_r;
  status_t                out_status_r;
  count_t                 out_count_r;

  logic [TIME_BITS-1:0]   chain [CAPACITY];
  cell_flags_t            cell_flags [CAPACITY];
  logic [PAD-1:0]         le_vec;
  logic [PAD-1:0]         near_vec;
  count_t                 scan_count;
  logic                   scan_conflict;
  logic                   scan_last;
  logic                   full;
  logic                   insert;
  logic                   cfg_write;
  status_t                status_nxt;
  count_t                 count_nxt;

  assign scan_last = (state_r == S_SCAN) && (chunk_r == CHW'(NCHUNK - 1));
  assign full      = (fill_r == FILLW'(CAPACITY));
  assign insert    = scan_last && (kind_r == REQ_RESERVE) && !scan_conflict && !full;
  assign cfg_write = psel && penable && pwrite && (reg_index_t'(paddr[2]) == REG_MIN_GAP);

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    grt_cell #(
      .TIME_BITS (TIME_BITS)
    ) u_cell (
      .clk      (clk),
      .shift_en (insert),
      .time_in  ((i == 0) ? req_time_r : chain[(i == 0) ? 0 : i - 1]),
      .time_out (chain[i]),
      .req_time (req_time_r),
      .min_gap  (min_gap_r),
      .occupied (FILLW'(i) < fill_r),
      .flags    (cell_flags[i])
    );
  end

  always_comb begin
    le_vec   = '0;
    near_vec = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      le_vec[i]   = cell_flags[i].le;
      near_vec[i] = cell_flags[i].near;
    end
  end

  grt_scan #(
    .PAD (PAD)
  ) u_scan (
    .clk          (clk),
    .load         (state_r == S_CMP),
    .step         (state_r == S_SCAN),
    .le_in        (le_vec),
    .near_in      (near_vec),
    .count_nxt    (scan_count),
    .conflict_nxt (scan_conflict)
  );

  always_comb begin
    if (kind_r == REQ_COUNT) begin
      status_nxt = STATUS_OK;
      count_nxt  = scan_count;
    end else begin
      count_nxt = '0;
      if (scan_conflict) begin
        status_nxt = STATUS_CONFLICT;
      end else if (full) begin
        status_nxt = STATUS_FULL;
      end else begin
        status_nxt = STATUS_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      chunk_r     <= '0;
      fill_r      <= '0;
      min_gap_r   <= MIN_GAP_RESET;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_write) begin
        min_gap_r <= pwdata[GAP_BITS-1:0];
      end
      case (state_r)
        S_IDLE: begin
          if (start) begin
            state_r <= S_CMP;
          end
        end
        S_CMP: begin
          chunk_r <= '0;
          state_r <= S_SCAN;
        end
        S_SCAN: begin
          chunk_r <= chunk_r + CHW'(1);
          if (scan_last) begin
            state_r     <= S_IDLE;
            out_valid_r <= 1'b1;
            if (insert) begin
              fill_r <= fill_r + FILLW'(1);
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start && (state_r == S_IDLE)) begin
      kind_r     <= req_type_t'(in_req_type);
      req_time_r <= TIME_BITS'(in_request_time);
    end
    if (scan_last) begin
      out_status_r <= status_nxt;
      out_count_r  <= count_nxt;
    end
  end

  assign busy                  = (state_r != S_IDLE);
  assign out_valid             = out_valid_r;
  assign out_status            = out_status_r;
  assign out_count_at_or_below = out_count_r;
  assign pready                = 1'b1;
  assign prdata = (reg_index_t'(paddr[2]) == REG_MIN_GAP) ? CFG_DATA_BITS'(min_gap_r) : '0;

endmodule

[rtl/grt_checker.sv]
`include "gap_checked_reservation_table_assert.svh"

module grt_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               start,
  input logic                               busy,
  input logic                               out_valid,
  input logic [grt_pkg::STATUS_BITS-1:0]    out_status,
  input logic [grt_pkg::COUNT_BITS-1:0]     out_count_at_or_below
);
  import grt_pkg::*;

  `GRT_ASSERT_NEXT(a_accept_goes_busy, start && !busy, busy)
  `GRT_ASSERT_NEXT(a_single_result_cycle, out_valid, !out_valid)
  `GRT_ASSERT_NOW(a_result_ends_busy, $fell(busy) && $past(rst_n), out_valid)
  `GRT_ASSERT_NOW(a_refusal_has_no_count, out_valid && (out_status != STATUS_OK), out_count_at_or_below == '0)

endmodule

bind gap_checked_reservation_table grt_checker u_grt_checker (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .start                 (start),
  .busy                  (busy),
  .out_valid             (out_valid),
  .out_status            (out_status),
  .out_count_at_or_below (out_count_at_or_below)
);
